@@ hw/rtl/uvwrps_pkg.sv @@
// Shared types and constants of the uvw rotate / phase shift core.
// Request and result payload structs, configuration register indexes, pipeline controls.
// No dependencies.
package uvwrps_pkg;

	// Coordinate width is fixed by the payload fields (signed Q24.8).
	localparam int COORD_BITS = 32;
	// Default rotation coefficient width (signed Q2.18).
	localparam int COEF_BITS_DEF = 20;

	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROT_ROW_U    = 3'd0,
		REG_ROT_ROW_V    = 3'd1,
		REG_ROT_ROW_W    = 3'd2,
		REG_REPROJ_ROW_U = 3'd3,
		REG_REPROJ_ROW_V = 3'd4,
		REG_REPROJ_EN    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] u_in;
		logic signed [COORD_BITS-1:0] v_in;
		logic signed [COORD_BITS-1:0] w_in;
	} in_req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] u_out;
		logic signed [COORD_BITS-1:0] v_out;
		logic signed [COORD_BITS-1:0] w_out;
		logic signed [COORD_BITS-1:0] path_difference;
		logic                         saturated;
	} out_res_t;

	// Load enables of the two register stages of one dot-product unit.
	typedef struct packed {
		logic mul_en;
		logic sum_en;
	} dot_ctl_t;

endpackage

@@ hw/rtl/uvwrps_dot.sv @@
// Pipelined signed dot product with round-half-up: products registered, then the
// rounded sum registered. Depends on uvwrps_pkg for the stage control struct.
module uvwrps_dot #(
	parameter int A_BITS = 32,
	parameter int C_BITS = 20,
	parameter int TERMS  = 3,
	parameter int FRAC   = 18,
	localparam int P_BITS = A_BITS + C_BITS,
	localparam int S_BITS = P_BITS + $clog2(TERMS)
) (
	input  logic                             clk,
	input  uvwrps_pkg::dot_ctl_t             ctl,
	input  logic signed [A_BITS-1:0]         a [TERMS],
	input  logic signed [C_BITS-1:0]         c [TERMS],
	output logic signed [S_BITS-FRAC-1:0]    sum_s2
);

	localparam logic signed [S_BITS-1:0] HALF = S_BITS'(1) <<< (FRAC - 1);

	logic signed [P_BITS-1:0] prod_s1 [TERMS];
	logic signed [S_BITS-1:0] acc;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			for (int i = 0; i < TERMS; i++) begin
				prod_s1[i] <= a[i] * c[i];
			end
		end
	end

	// Exact sum plus half an LSB; the floor comes from dropping the fraction bits.
	always_comb begin
		acc = HALF;
		for (int i = 0; i < TERMS; i++) begin
			acc = acc + S_BITS'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			sum_s2 <= acc[S_BITS-1:FRAC];
		end
	end

endmodule

@@ hw/rtl/uvw_rotate_phase_shift_core.sv @@
// An accepted request passes six register stages before its result shows on out_valid.
// Throughput: one request per cycle while in_stall is low; each stage holds under stall on its
// own, so bubbles close up and the input keeps flowing while a result waits at the output.
// in_stall rises only when all six stages are full and the output is stalled.
// Reset clears every stage valid bit, loads identity matrices and turns reprojection off.
module uvw_rotate_phase_shift_core #(
	parameter int COEF_BITS = uvwrps_pkg::COEF_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_wr_en,
	input  logic [uvwrps_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [3*COEF_BITS-1:0]                     cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  uvwrps_pkg::in_req_t                        in_req,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output uvwrps_pkg::out_res_t                       out_res
);

	localparam int CW   = uvwrps_pkg::COORD_BITS;
	localparam int CB   = COEF_BITS;
	localparam int RB   = 3 * CB;
	localparam int PB   = CB + 4;
	localparam int WIDE = CW + 5;

	localparam logic [RB-1:0]     ROT_U_RST = RB'(1) << (CB - 2);
	localparam logic [RB-1:0]     ROT_V_RST = ROT_U_RST << CB;
	localparam logic [RB-1:0]     ROT_W_RST = ROT_U_RST << (2 * CB);
	localparam logic [2*PB-1:0]   RP_U_RST  = (2*PB)'(1) << CB;
	localparam logic [2*PB-1:0]   RP_V_RST  = RP_U_RST << PB;
	localparam logic signed [CB:0] ROT_ONE  = (CB+1)'(1) << (CB - 2);

	localparam logic signed [WIDE-1:0] CMAX =
		$signed({{(WIDE-CW+1){1'b0}}, {(CW-1){1'b1}}});
	localparam logic signed [WIDE-1:0] CMIN = ~CMAX;

	function automatic logic signed [CW-1:0] clip_coord(
		input  logic signed [WIDE-1:0] v,
		output logic                   hit
	);
		logic signed [CW-1:0] res;
		hit = (v > CMAX) || (v < CMIN);
		if (!hit) begin
			res = v[CW-1:0];
		end else if (v[WIDE-1]) begin
			res = CMIN[CW-1:0];
		end else begin
			res = CMAX[CW-1:0];
		end
		return res;
	endfunction

	// Configuration registers
	logic [RB-1:0]   rot_q [3];
	logic [2*PB-1:0] rp_q [2];
	logic            reproj_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]    <= ROT_U_RST;
			rot_q[1]    <= ROT_V_RST;
			rot_q[2]    <= ROT_W_RST;
			rp_q[0]     <= RP_U_RST;
			rp_q[1]     <= RP_V_RST;
			reproj_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				uvwrps_pkg::REG_ROT_ROW_U:    rot_q[0]    <= cfg_data;
				uvwrps_pkg::REG_ROT_ROW_V:    rot_q[1]    <= cfg_data;
				uvwrps_pkg::REG_ROT_ROW_W:    rot_q[2]    <= cfg_data;
				uvwrps_pkg::REG_REPROJ_ROW_U: rp_q[0]     <= cfg_data[2*PB-1:0];
				uvwrps_pkg::REG_REPROJ_ROW_V: rp_q[1]     <= cfg_data[2*PB-1:0];
				uvwrps_pkg::REG_REPROJ_EN:    reproj_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Coefficient unpacking
	logic signed [CB-1:0] rot_c [3][3];
	logic signed [CB:0]   pd_c [3];
	logic signed [PB-1:0] rp_c [2][2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot_c[i][j] = rot_q[i][j*CB +: CB];
			end
			pd_c[i] = (CB+1)'(rot_q[i][2*CB +: CB] );
		end
		// Third column minus the unit w vector.
		pd_c[2] = (CB+1)'($signed(rot_q[2][2*CB +: CB])) - ROT_ONE;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				rp_c[i][j] = rp_q[i][j*PB +: PB];
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (i != 2) begin
				pd_c[i] = (CB+1)'($signed(rot_q[i][2*CB +: CB]));
			end
		end
	end

	// Stage valid bits and advance chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !valid_s6 || !out_stall;
	assign adv5 = !valid_s5 || adv6;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign in_stall  = !adv1;
	assign out_valid = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
			if (adv5) begin
				valid_s5 <= valid_s4;
			end
			if (adv6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// Stages 1-2: rotation products and rounded row sums
	logic signed [CW-1:0]   x [3];
	logic signed [CW+3:0]   rot_sum [3];
	uvwrps_pkg::dot_ctl_t   rot_ctl;

	assign x[0] = in_req.u_in;
	assign x[1] = in_req.v_in;
	assign x[2] = in_req.w_in;

	assign rot_ctl.mul_en = adv1;
	assign rot_ctl.sum_en = adv2;

	for (genvar g = 0; g < 3; g++) begin : g_rot
		uvwrps_dot #(
			.A_BITS(CW),
			.C_BITS(CB),
			.TERMS (3),
			.FRAC  (CB - 2)
		) u_rot (
			.clk   (clk),
			.ctl   (rot_ctl),
			.a     (x),
			.c     (rot_c[g]),
			.sum_s2(rot_sum[g])
		);
	end

	// Stage 3: clip rotated coordinates
	logic signed [CW-1:0] r_c [3];
	logic [2:0]           r_hit;
	logic signed [CW-1:0] r_s3 [3];
	logic                 sat_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i] = clip_coord(WIDE'(rot_sum[i]), r_hit[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			r_s3   <= r_c;
			sat_s3 <= |r_hit;
		end
	end

	// Stages 4-5: path difference and reprojection dot products
	logic signed [CW-1:0]   r_uv [2];
	logic signed [WIDE-1:0] pd_sum;
	logic signed [WIDE-1:0] rp_sum [2];
	uvwrps_pkg::dot_ctl_t   pr_ctl;
	logic signed [CW-1:0]   r_s4 [3];
	logic signed [CW-1:0]   r_s5 [3];
	logic                   sat_s4, sat_s5;

	assign r_uv[0] = r_s3[0];
	assign r_uv[1] = r_s3[1];

	assign pr_ctl.mul_en = adv4;
	assign pr_ctl.sum_en = adv5;

	uvwrps_dot #(
		.A_BITS(CW),
		.C_BITS(CB + 1),
		.TERMS (3),
		.FRAC  (CB - 2)
	) u_pd (
		.clk   (clk),
		.ctl   (pr_ctl),
		.a     (r_s3),
		.c     (pd_c),
		.sum_s2(pd_sum)
	);

	for (genvar g = 0; g < 2; g++) begin : g_rp
		uvwrps_dot #(
			.A_BITS(CW),
			.C_BITS(PB),
			.TERMS (2),
			.FRAC  (CB)
		) u_rp (
			.clk   (clk),
			.ctl   (pr_ctl),
			.a     (r_uv),
			.c     (rp_c[g]),
			.sum_s2(rp_sum[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			r_s4   <= r_s3;
			sat_s4 <= sat_s3;
		end
		if (adv5) begin
			r_s5   <= r_s4;
			sat_s5 <= sat_s4;
		end
	end

	// Stage 6: final clip, select and output register
	logic signed [CW-1:0] pd_c6, rpu_c6, rpv_c6;
	logic                 pd_hit, rpu_hit, rpv_hit;
	uvwrps_pkg::out_res_t res_c;
	uvwrps_pkg::out_res_t res_s6;

	always_comb begin
		pd_c6  = clip_coord(pd_sum, pd_hit);
		rpu_c6 = clip_coord(rp_sum[0], rpu_hit);
		rpv_c6 = clip_coord(rp_sum[1], rpv_hit);
		res_c.w_out           = r_s5[2];
		res_c.path_difference = pd_c6;
		if (reproj_en_q) begin
			res_c.u_out     = rpu_c6;
			res_c.v_out     = rpv_c6;
			res_c.saturated = sat_s5 || pd_hit || rpu_hit || rpv_hit;
		end else begin
			res_c.u_out     = r_s5[0];
			res_c.v_out     = r_s5[1];
			res_c.saturated = sat_s5 || pd_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			res_s6 <= res_c;
		end
	end

	assign out_res = res_s6;

	// Input backs up only when every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 &&
			valid_s6 && out_stall))
		else $error("input stalled with a free pipeline slot");

	// An accepted request lands in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request lost at pipeline entry");

	// A blocked stage 5 keeps its item.
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !adv5 |=> valid_s5 && $stable(r_s5[0]) && $stable(sat_s5))
		else $error("stage 5 item changed while blocked");

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for the uvw rotate / phase shift core.
// A small tracker predicts rotated, reprojected and path-difference results per request.
// Depends on uvwrps_pkg and uvw_rotate_phase_shift_core.
`timescale 1ns / 100ps

module tb_top;

	localparam int COEF_BITS = uvwrps_pkg::COEF_BITS_DEF;
	localparam int COORD_BITS = uvwrps_pkg::COORD_BITS;
	localparam int ROW_BITS = 3 * COEF_BITS;
	localparam int RP_BITS = COEF_BITS + 4;
	localparam int ROT_FRAC = COEF_BITS - 2;
	localparam int RP_FRAC = COEF_BITS;
	localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam int REG_COUNT = int'(uvwrps_pkg::REG_REPROJ_EN) + 1;
	localparam int LATENCY = 6;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_OFF_CYCLES = 90;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int DIRECTED_ITEMS = 8;

	typedef logic [ROW_BITS-1:0] reg_word_t;

	class uvw_result_tracker;
		reg_word_t rot_rows[3];
		reg_word_t reproj_rows[2];
		bit reproj_on;
		bit clip_seen;
		uvwrps_pkg::out_res_t expected_q[$];
		int unsigned fail_count;

		function new();
			rot_rows[0] = reg_word_t'(1) << ROT_FRAC;
			rot_rows[1] = reg_word_t'(1) << (ROT_FRAC + COEF_BITS);
			rot_rows[2] = reg_word_t'(1) << (ROT_FRAC + 2 * COEF_BITS);
			reproj_rows[0] = reg_word_t'(1) << RP_FRAC;
			reproj_rows[1] = reg_word_t'(1) << (RP_FRAC + RP_BITS);
			reproj_on = 1'b0;
			fail_count = 0;
		endfunction

		function void write_register(uvwrps_pkg::cfg_reg_t idx, reg_word_t data);
			case (idx)
				uvwrps_pkg::REG_ROT_ROW_U: rot_rows[0] = data;
				uvwrps_pkg::REG_ROT_ROW_V: rot_rows[1] = data;
				uvwrps_pkg::REG_ROT_ROW_W: rot_rows[2] = data;
				uvwrps_pkg::REG_REPROJ_ROW_U: reproj_rows[0] = data;
				uvwrps_pkg::REG_REPROJ_ROW_V: reproj_rows[1] = data;
				uvwrps_pkg::REG_REPROJ_EN: reproj_on = data[0];
				default: ;
			endcase
		endfunction

		function longint rot_coef(int row, int col);
			logic signed [COEF_BITS-1:0] c;
			c = rot_rows[row][col*COEF_BITS +: COEF_BITS];
			return longint'(c);
		endfunction

		function longint reproj_coef(int row, int col);
			logic signed [RP_BITS-1:0] c;
			c = reproj_rows[row][col*RP_BITS +: RP_BITS];
			return longint'(c);
		endfunction

		// Round half up to the coordinate LSB, then clip to the coordinate range.
		function longint round_clip(longint acc, int frac);
			longint q;
			q = (acc + (longint'(1) << (frac - 1))) >>> frac;
			if (q > COORD_MAX) begin
				clip_seen = 1'b1;
				q = COORD_MAX;
			end else if (q < COORD_MIN) begin
				clip_seen = 1'b1;
				q = COORD_MIN;
			end
			return q;
		endfunction

		function uvwrps_pkg::out_res_t rotate_uvw(uvwrps_pkg::in_req_t req);
			longint x[3];
			longint r[3];
			longint uv[2];
			longint acc;
			longint pcoef;
			longint pd;
			uvwrps_pkg::out_res_t res;
			clip_seen = 1'b0;
			x[0] = longint'(req.u_in);
			x[1] = longint'(req.v_in);
			x[2] = longint'(req.w_in);
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += x[j] * rot_coef(i, j);
				r[i] = round_clip(acc, ROT_FRAC);
			end
			// third column minus unit w, against the already clipped rotation
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				pcoef = rot_coef(i, 2);
				if (i == 2)
					pcoef -= longint'(1) << ROT_FRAC;
				acc += r[i] * pcoef;
			end
			pd = round_clip(acc, ROT_FRAC);
			if (reproj_on) begin
				for (int k = 0; k < 2; k++) begin
					acc = r[0] * reproj_coef(k, 0) + r[1] * reproj_coef(k, 1);
					uv[k] = round_clip(acc, RP_FRAC);
				end
			end else begin
				uv[0] = r[0];
				uv[1] = r[1];
			end
			res.u_out = uv[0][COORD_BITS-1:0];
			res.v_out = uv[1][COORD_BITS-1:0];
			res.w_out = r[2][COORD_BITS-1:0];
			res.path_difference = pd[COORD_BITS-1:0];
			res.saturated = clip_seen;
			return res;
		endfunction

		function void note_request(uvwrps_pkg::in_req_t req);
			expected_q.push_back(rotate_uvw(req));
		endfunction

		function void compare_field(string name, logic signed [COORD_BITS-1:0] want,
				logic signed [COORD_BITS-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_result(uvwrps_pkg::out_res_t got);
			uvwrps_pkg::out_res_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding: u_out %0d", got.u_out);
				fail_count++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("u_out", want.u_out, got.u_out);
			compare_field("v_out", want.v_out, got.v_out);
			compare_field("w_out", want.w_out, got.w_out);
			compare_field("path_difference", want.path_difference, got.path_difference);
			compare_field("saturated", COORD_BITS'(want.saturated),
				COORD_BITS'(got.saturated));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [uvwrps_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	reg_word_t cfg_data;
	logic in_valid;
	logic in_stall;
	uvwrps_pkg::in_req_t in_req;
	logic out_valid;
	logic out_stall;
	uvwrps_pkg::out_res_t out_res;

	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_off_req;
	int unsigned quiet_cycles;
	reg_word_t reg_image[REG_COUNT];
	uvw_result_tracker tracker = new();

	uvw_rotate_phase_shift_core #(
		.COEF_BITS(COEF_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_request(in_req);
			if (out_valid && !out_stall)
				tracker.check_result(out_res);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic logic [COORD_BITS-1:0] pick_coord();
		logic [COORD_BITS-1:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom();
			2: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = '1;
					2: v = {1'b0, {(COORD_BITS - 1){1'b1}}};
					3: v = {1'b1, {(COORD_BITS - 1){1'b0}}};
					default: v = COORD_BITS'(1);
				endcase
			end
			default: begin
				v = $urandom() >> $urandom_range(8, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic uvwrps_pkg::in_req_t random_item();
		uvwrps_pkg::in_req_t r;
		r.u_in = pick_coord();
		r.v_in = pick_coord();
		r.w_in = pick_coord();
		return r;
	endfunction

	function automatic uvwrps_pkg::in_req_t directed_item(int k);
		logic [COORD_BITS-1:0] cmax;
		logic [COORD_BITS-1:0] cmin;
		logic [COORD_BITS-1:0] ones;
		uvwrps_pkg::in_req_t r;
		cmax = {1'b0, {(COORD_BITS - 1){1'b1}}};
		cmin = {1'b1, {(COORD_BITS - 1){1'b0}}};
		ones = '1;
		case (k)
			0: r = '0;
			1: r = {cmax, cmax, cmax};
			2: r = {cmin, cmin, cmin};
			3: r = {cmax, cmin, {COORD_BITS{1'b0}}};
			4: r = {COORD_BITS'(1), ones, COORD_BITS'(1)};
			// half an LSB either way exercises round half up
			5: r = {COORD_BITS'(128), -COORD_BITS'(128), COORD_BITS'(32'h7fff_ff00)};
			6: r = {COORD_BITS'(32'h5555_5555), COORD_BITS'(32'haaaa_aaaa),
				COORD_BITS'(32'h0f0f_0f0f)};
			default: r = {cmin, cmax, ones};
		endcase
		return r;
	endfunction

	function automatic reg_word_t rand_word();
		return ROW_BITS'({$urandom(), $urandom()});
	endfunction

	function automatic logic [COEF_BITS-1:0] rot_near(int center, int span);
		return COEF_BITS'(center + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [RP_BITS-1:0] rp_near(int center, int span);
		return RP_BITS'(center + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic reg_word_t reproj_row(logic [RP_BITS-1:0] c0, logic [RP_BITS-1:0] c1);
		reg_word_t w;
		// bits above the two coefficients are don't-care
		w = rand_word();
		w[2*RP_BITS-1:0] = {c1, c0};
		return w;
	endfunction

	task automatic prepare_setting(int phase);
		logic [COEF_BITS-1:0] one;
		logic [COEF_BITS-1:0] half;
		logic [COEF_BITS-1:0] quarter;
		logic [COEF_BITS-1:0] zero;
		logic [COEF_BITS-1:0] cmax;
		logic [COEF_BITS-1:0] cmin;
		logic [RP_BITS-1:0] rp_one;
		logic [RP_BITS-1:0] rp_zero;
		logic [RP_BITS-1:0] rp_max;
		logic [RP_BITS-1:0] rp_min;
		int sign;
		one = COEF_BITS'(1) << ROT_FRAC;
		half = one >> 1;
		quarter = one >> 2;
		zero = '0;
		cmax = {1'b0, {(COEF_BITS - 1){1'b1}}};
		cmin = {1'b1, {(COEF_BITS - 1){1'b0}}};
		rp_one = RP_BITS'(1) << RP_FRAC;
		rp_zero = '0;
		rp_max = {1'b0, {(RP_BITS - 1){1'b1}}};
		rp_min = {1'b1, {(RP_BITS - 1){1'b0}}};
		reg_image[uvwrps_pkg::REG_REPROJ_EN] = rand_word() | reg_word_t'(1);
		case (phase)
			1: begin
				reg_image[uvwrps_pkg::REG_ROT_ROW_U] = {quarter, zero, half};
				reg_image[uvwrps_pkg::REG_ROT_ROW_V] = {-quarter, half, zero};
				reg_image[uvwrps_pkg::REG_ROT_ROW_W] = {half, zero, quarter};
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = reproj_row(rp_one >> 1, rp_zero);
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = reproj_row(rp_zero,
					-(rp_one >> 1));
			end
			2: begin
				reg_image[uvwrps_pkg::REG_ROT_ROW_U] = {cmax, cmax, cmax};
				reg_image[uvwrps_pkg::REG_ROT_ROW_V] = {cmax, cmax, cmax};
				reg_image[uvwrps_pkg::REG_ROT_ROW_W] = {cmax, cmax, cmax};
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = reproj_row(rp_max, rp_max);
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = reproj_row(rp_max, rp_max);
			end
			3: begin
				reg_image[uvwrps_pkg::REG_ROT_ROW_U] = {cmin, cmin, cmin};
				reg_image[uvwrps_pkg::REG_ROT_ROW_V] = {cmin, cmin, cmin};
				reg_image[uvwrps_pkg::REG_ROT_ROW_W] = {cmin, cmin, cmin};
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = reproj_row(rp_min, rp_min);
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = reproj_row(rp_min, rp_min);
			end
			4: begin
				reg_image[uvwrps_pkg::REG_ROT_ROW_U] = '0;
				reg_image[uvwrps_pkg::REG_ROT_ROW_V] = '0;
				reg_image[uvwrps_pkg::REG_ROT_ROW_W] = '0;
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = reproj_row(rp_zero, rp_zero);
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = reproj_row(rp_zero, rp_zero);
			end
			PHASES - 1: begin
				reg_image[uvwrps_pkg::REG_ROT_ROW_U] = {zero, zero, one};
				reg_image[uvwrps_pkg::REG_ROT_ROW_V] = {zero, one, zero};
				reg_image[uvwrps_pkg::REG_ROT_ROW_W] = {one, zero, zero};
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = reproj_row(rp_one, rp_zero);
				reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = reproj_row(rp_zero, rp_one);
				reg_image[uvwrps_pkg::REG_REPROJ_EN] = rand_word() & ~reg_word_t'(1);
			end
			default: begin
				reg_image[uvwrps_pkg::REG_REPROJ_EN] = rand_word();
				if (phase % 2) begin
					reg_image[uvwrps_pkg::REG_ROT_ROW_U] = rand_word();
					reg_image[uvwrps_pkg::REG_ROT_ROW_V] = rand_word();
					reg_image[uvwrps_pkg::REG_ROT_ROW_W] = rand_word();
					reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = rand_word();
					reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = rand_word();
				end else begin
					// near a rotation: diagonal close to +-1, small cross terms
					sign = $urandom_range(0, 1) ? 1 : -1;
					reg_image[uvwrps_pkg::REG_ROT_ROW_U] = {rot_near(0, 1 << 17),
						rot_near(0, 1 << 17), rot_near(sign * int'(one), 1 << 16)};
					reg_image[uvwrps_pkg::REG_ROT_ROW_V] = {rot_near(0, 1 << 17),
						rot_near(sign * int'(one), 1 << 16), rot_near(0, 1 << 17)};
					reg_image[uvwrps_pkg::REG_ROT_ROW_W] = {rot_near(int'(one), 1 << 16),
						rot_near(0, 1 << 17), rot_near(0, 1 << 17)};
					reg_image[uvwrps_pkg::REG_REPROJ_ROW_U] = reproj_row(
						rp_near(int'(rp_one), 1 << 18), rp_near(0, 1 << 18));
					reg_image[uvwrps_pkg::REG_REPROJ_ROW_V] = reproj_row(
						rp_near(0, 1 << 18), rp_near(int'(rp_one), 1 << 18));
				end
			end
		endcase
	endtask

	task automatic load_registers();
		for (int i = int'(uvwrps_pkg::REG_ROT_ROW_U); i <= int'(uvwrps_pkg::REG_REPROJ_EN);
				i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= uvwrps_pkg::CFG_INDEX_BITS'(i);
			cfg_data <= reg_image[i];
			@(posedge clk);
			tracker.write_register(uvwrps_pkg::cfg_reg_t'(i), reg_image[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_request(uvwrps_pkg::in_req_t r);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_req <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic run_phase(int phase);
		int n_dir;
		n_dir = (phase < 3) ? DIRECTED_ITEMS : 0;
		tx_idle_on = (phase != PHASES - 1);
		rx_idle_on = (phase != PHASES - 1);
		for (int k = 0; k < n_dir; k++)
			send_request(directed_item(k));
		// hold the output while requests keep coming, so the pipe fills up
		if (phase == 1)
			hold_off_req = 1'b1;
		for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (phase == 1)
				tx_idle_on = (k >= 60);
			send_request(random_item());
		end
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.expected_q.size() != 0);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// first phase runs on the reset register values
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				prepare_setting(phase);
				load_registers();
			end
			run_phase(phase);
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (tracker.fail_count == 0 && tracker.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/uvwrps_pkg.sv
hw/rtl/uvwrps_dot.sv
hw/rtl/uvw_rotate_phase_shift_core.sv
dv/tb_top.sv
